// File: sv/wmvn_pkg.sv
// ----------------------------------------------------------------------------
// wmvn_pkg
// Types and constants shared by the weighted mean vector norm block.
// ----------------------------------------------------------------------------
package wmvn_pkg;

  localparam int MAX_COMPONENTS_DEF = 16;

  localparam int WEIGHT_W = 16;
  localparam int INDEX_W  = 4;
  localparam int VALUE_W  = 16;
  localparam int NCOMP_W  = 5;
  localparam int NORM_W   = 18;

  localparam int SUM_W  = 48;             // component sums, 29 fraction bits
  localparam int PROD_W = WEIGHT_W + VALUE_W + 1;
  localparam int TW_W   = 32;             // total weight, Q.15
  localparam int Q_W    = 19;             // capped mean component magnitude

  localparam logic [NCOMP_W-1:0] NCOMP_RESET = NCOMP_W'(3);
  localparam logic [Q_W-1:0]     Q_CAP       = Q_W'(262144);
  localparam logic [NORM_W-1:0]  NORM_MAX    = NORM_W'(262143);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic        [WEIGHT_W-1:0] weight;
    logic        [INDEX_W-1:0]  comp_index;
    logic signed [VALUE_W-1:0]  comp_value;
    logic                       end_of_set;
  } in_item_t;

  typedef struct packed {
    logic [NORM_W-1:0] mean_norm;
    logic              zero_weight;
  } out_item_t;

endpackage

// File: sv/weighted_mean_vector_norm_top.sv
// ----------------------------------------------------------------------------
// weighted_mean_vector_norm_top
// Weighted mean vector norm: per-component weighted sums in a RAM, then a
// serial divide / square / integer square root on the end-of-set item.
// ----------------------------------------------------------------------------
// Accumulation item: accept, RAM read + product, write back; in_stall is
//   high while the sequencer is out of idle, so no new item is taken before
//   the last one is written back. End-of-set item: each of the n =
//   min(num_components, MAX_COMPONENTS) components takes a 48-step restoring
//   divide, and the root takes one bit per cycle (21 steps at the default size).
// Reset (synchronous, rst_n low): sums read as zero through per-entry valid
//   bits, no clearing pass; total weight 0; num_components 3; no result held.
// ----------------------------------------------------------------------------
module weighted_mean_vector_norm_top
  import wmvn_pkg::*;
#(
  parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  // configuration: num_components
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [NCOMP_W-1:0] cfg_data
);

  // Sizes that follow from the component count
  localparam int IDX_W   = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int CNT_W   = $clog2(MAX_COMPONENTS + 1);
  localparam int ACC_W0  = 2 * Q_W - 1 + $clog2(MAX_COMPONENTS);
  localparam int ACC_W   = ACC_W0 + (ACC_W0 % 2);   // even, for the root
  localparam int RT_W    = ACC_W / 2;
  localparam int REM_W   = RT_W + 2;
  localparam int DCNT_W  = $clog2(SUM_W);
  localparam int SCNT_W  = $clog2(RT_W);

  typedef enum logic [3:0] {
    S_IDLE,   // waiting for an item
    S_RD,     // RAM read in flight, product registered
    S_ACC,    // saturating add, write back
    S_NSTART, // decide zero weight / empty vector
    S_NRD,    // read component sum
    S_NMAG,   // magnitude, load divider
    S_NDIV,   // one quotient bit per cycle
    S_NCAP,   // cap quotient
    S_NMUL,   // square
    S_NADD,   // add to sum of squares
    S_SINIT,  // load root unit
    S_SQRT,   // one root bit per cycle
    S_DONE    // hand result to output register, clear sums
  } state_t;

  state_t state_r;

  // --------------------------------------------------------------------------
  // Configuration: single register, always ready
  // --------------------------------------------------------------------------
  logic [NCOMP_W-1:0] ncomp_r;
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // Component sum RAM with registered read data, plus per-entry valid bits
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] mem [MAX_COMPONENTS];
  logic [MAX_COMPONENTS-1:0] vld_r;

  logic [IDX_W-1:0]        raddr;
  logic signed [SUM_W-1:0] rdata_r;
  logic                    rvld_r;
  logic                    mem_we;
  logic [IDX_W-1:0]        waddr;
  logic signed [SUM_W-1:0] wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
    rvld_r  <= vld_r[raddr];
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  in_item_t                 item_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  base_r;
  logic [TW_W-1:0]          tw_r;
  logic [CNT_W-1:0]         n_r;
  logic [CNT_W-1:0]         comp_i_r;
  logic [SUM_W-1:0]         dq_r;      // dividend shifting out, quotient in
  logic [TW_W-1:0]          rem_r;
  logic [DCNT_W-1:0]        dcnt_r;
  logic [Q_W-1:0]           qcap_r;
  logic [2*Q_W-1:0]         sq_r;
  logic [ACC_W-1:0]         acc_r;
  logic [ACC_W-1:0]         sv_r;      // radicand, shifting out two bits a step
  logic [REM_W-1:0]         srem_r;
  logic [RT_W-1:0]          root_r;
  logic [SCNT_W-1:0]        scnt_r;
  logic                     zw_r;
  logic                     out_valid_r;
  out_item_t                out_data_r;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // result register takes the new item once it is free or draining
  logic out_load;
  assign out_load = (state_r == S_DONE) && !(out_valid_r && out_stall);

  assign raddr = (state_r == S_NRD) ? IDX_W'(comp_i_r) : IDX_W'(in_data.comp_index);

  // Item's index lands in storage
  logic in_range;
  assign in_range = (32'(item_r.comp_index) < MAX_COMPONENTS);

  // Saturating sum update
  logic signed [SUM_W:0] sum_wide;
  logic signed [SUM_W-1:0] sum_nxt;
  always_comb begin
    sum_wide = {base_r[SUM_W-1], base_r} + (SUM_W+1)'(prod_r);
    if (sum_wide > (SUM_W+1)'(SUM_MAX)) begin
      sum_nxt = SUM_MAX;
    end else if (sum_wide < (SUM_W+1)'(SUM_MIN)) begin
      sum_nxt = SUM_MIN;
    end else begin
      sum_nxt = sum_wide[SUM_W-1:0];
    end
  end

  assign mem_we = (state_r == S_ACC) && in_range;
  assign waddr  = IDX_W'(item_r.comp_index);
  assign wdata  = sum_nxt;

  // Saturating total weight update
  logic [TW_W:0]   tw_wide;
  logic [TW_W-1:0] tw_nxt;
  assign tw_wide = {1'b0, tw_r} + (TW_W+1)'(item_r.weight);
  assign tw_nxt  = tw_wide[TW_W] ? {TW_W{1'b1}} : tw_wide[TW_W-1:0];

  // Effective component count
  logic [CNT_W-1:0] n_eff;
  assign n_eff = (32'(ncomp_r) > MAX_COMPONENTS) ? CNT_W'(MAX_COMPONENTS)
                                                 : CNT_W'(ncomp_r);

  // Magnitude of the sum just read (invalid entry reads as zero)
  logic signed [SUM_W-1:0] rsum;
  logic [SUM_W-1:0]        rmag;
  assign rsum = rvld_r ? rdata_r : '0;
  assign rmag = rsum[SUM_W-1] ? SUM_W'(-rsum) : SUM_W'(rsum);

  // Restoring divide step
  logic [TW_W:0]   dtrial;
  logic            dge;
  logic [TW_W-1:0] rem_nxt;
  logic [TW_W:0]   ddiff;
  assign dtrial  = {rem_r, dq_r[SUM_W-1]};
  assign dge     = (dtrial >= {1'b0, tw_r});
  assign ddiff   = dtrial - {1'b0, tw_r};
  assign rem_nxt = dge ? ddiff[TW_W-1:0] : dtrial[TW_W-1:0];

  // Integer square root step, two radicand bits per step
  logic [REM_W-1:0] st;
  logic [REM_W-1:0] strial;
  logic             sge;
  assign st     = {srem_r[REM_W-3:0], sv_r[ACC_W-1 -: 2]};
  assign strial = {root_r, 2'b01};
  assign sge    = (st >= strial);

  logic [NORM_W-1:0] norm_sat;
  assign norm_sat = (root_r > RT_W'(NORM_MAX)) ? NORM_MAX : root_r[NORM_W-1:0];

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ncomp_r     <= NCOMP_RESET;
      vld_r       <= '0;
      tw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ncomp_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            item_r  <= in_data;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          prod_r  <= $signed({1'b0, item_r.weight}) * item_r.comp_value;
          base_r  <= rvld_r ? rdata_r : '0;
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (item_r.comp_index == '0) begin
            tw_r <= tw_nxt;
          end
          if (in_range) begin
            vld_r[waddr] <= 1'b1;
          end
          state_r <= item_r.end_of_set ? S_NSTART : S_IDLE;
        end
        S_NSTART: begin
          acc_r    <= '0;
          comp_i_r <= '0;
          n_r      <= n_eff;
          zw_r     <= (tw_r == '0);
          if (tw_r == '0) begin
            state_r <= S_DONE;
          end else if (n_eff == '0) begin
            state_r <= S_SINIT;
          end else begin
            state_r <= S_NRD;
          end
        end
        S_NRD: begin
          state_r <= S_NMAG;
        end
        S_NMAG: begin
          dq_r    <= rmag;
          rem_r   <= '0;
          dcnt_r  <= '0;
          state_r <= S_NDIV;
        end
        S_NDIV: begin
          rem_r  <= rem_nxt;
          dq_r   <= {dq_r[SUM_W-2:0], dge};
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DCNT_W'(SUM_W - 1)) begin
            state_r <= S_NCAP;
          end
        end
        S_NCAP: begin
          qcap_r  <= (dq_r > SUM_W'(Q_CAP)) ? Q_CAP : dq_r[Q_W-1:0];
          state_r <= S_NMUL;
        end
        S_NMUL: begin
          sq_r    <= qcap_r * qcap_r;
          state_r <= S_NADD;
        end
        S_NADD: begin
          acc_r    <= acc_r + ACC_W'(sq_r);
          comp_i_r <= comp_i_r + 1'b1;
          state_r  <= (comp_i_r + 1'b1 == n_r) ? S_SINIT : S_NRD;
        end
        S_SINIT: begin
          sv_r    <= acc_r;
          srem_r  <= '0;
          root_r  <= '0;
          scnt_r  <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          srem_r <= sge ? (st - strial) : st;
          root_r <= {root_r[RT_W-2:0], sge};
          sv_r   <= {sv_r[ACC_W-3:0], 2'b00};
          scnt_r <= scnt_r + 1'b1;
          if (scnt_r == SCNT_W'(RT_W - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // wait for the previous result to drain
          if (out_load) begin
            out_data_r.mean_norm   <= zw_r ? '0 : norm_sat;
            out_data_r.zero_weight <= zw_r;
            vld_r                  <= '0;
            tw_r                   <= '0;
            state_r                <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // an accepted item always blocks the next cycle (read-modify-write interlock)
  a_accept_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("item accepted during read-modify-write");

  // a result appears only out of the final state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("result raised outside of done state");

  // a zero-weight result carries norm zero
  a_zero_weight_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.zero_weight) |-> (out_data.mean_norm == '0))
    else $error("zero-weight result with nonzero norm");

  // RAM is written only for indexes that lie in storage
  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (32'(waddr) < MAX_COMPONENTS))
    else $error("RAM write beyond storage");

  // sums are cleared only when a result is handed over
  a_clear_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(vld_r != '0) && (vld_r == '0))
      |-> ($past(out_load) && out_valid))
    else $error("sums cleared without a result");

endmodule
